// ===== rtl/ges_pkg.sv =====
// Package for the Gaussian elimination solver: opcodes, widths, defaults
// and the token and control structs shared by the cell chain and top level.
// No dependencies.
package ges_pkg;

    localparam int MAX_DIM_DEF   = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int DIM_W         = 5;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

    typedef enum logic [1:0] {
        OP_LOAD_MAT = 2'd0,
        OP_LOAD_RHS = 2'd1,
        OP_SOLVE    = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // token moving down the cell chain
    typedef struct packed {
        logic                    valid;
        logic                    bs;     // 1: back substitution, 0: elimination
        logic signed [VAL_W-1:0] val;    // multiplier or running sum
    } t_tok;

    typedef struct packed {
        logic ld_mat;
        logic ld_rhs;
        logic copy;
        logic piv_ld;
        logic x_we;
    } t_ctl;

endpackage

// ===== rtl/ges_if.sv =====
// Valid/ready channel interfaces of the solver: configuration, input items,
// results. Depends on nothing.
interface ges_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ges_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic [3:0]         row;
    logic [3:0]         column;
    logic signed [31:0] value;
    modport source (output valid, output opcode, output row, output column,
                    output value, input ready);
    modport sink   (input valid, input opcode, input row, input column,
                    input value, output ready);
endinterface

interface ges_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         solution_index;
    logic signed [31:0] solution_value;
    logic               singular;
    logic               overflowed;
    logic               last;
    modport source (output valid, output solution_index, output solution_value,
                    output singular, output overflowed, output last, input ready);
    modport sink   (input valid, input solution_index, input solution_value,
                    input singular, input overflowed, input last, output ready);
endinterface

// ===== rtl/ges_div.sv =====
// Sequential fixed-point divider: (num * 2^FRAC_BITS) / den, truncated,
// saturated to 32 bits, one quotient bit per cycle. Uses ges_pkg.
module ges_div import ges_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [VAL_W-1:0] i_num,
    input  logic signed [VAL_W-1:0] i_den,
    output logic                    o_done,
    output logic signed [VAL_W-1:0] o_quot,
    output logic                    o_sat
);
    localparam int NUM_W = VAL_W + FRAC_BITS;
    localparam int CW    = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] LIM_P = NUM_W'(33'h0_7FFF_FFFF);
    localparam logic [NUM_W-1:0] LIM_N = NUM_W'(33'h0_8000_0000);

    logic [NUM_W-1:0] r_num;
    logic [VAL_W-1:0] r_den;
    logic [VAL_W-1:0] r_rem;
    logic             r_neg;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [VAL_W-1:0] w_num_mag;
    logic [VAL_W-1:0] w_den_mag;
    logic [VAL_W:0]   w_trial;
    logic             w_qbit;
    logic [VAL_W-1:0] w_q32;

    assign w_num_mag = i_num[VAL_W-1] ? VAL_W'(-i_num) : VAL_W'(i_num);
    assign w_den_mag = i_den[VAL_W-1] ? VAL_W'(-i_den) : VAL_W'(i_den);
    assign w_trial   = {r_rem, r_num[NUM_W-1]};
    assign w_qbit    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == CW'(1));
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(NUM_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_num_mag, {FRAC_BITS{1'b0}}};
            r_den <= w_den_mag;
            r_rem <= '0;
            r_neg <= i_num[VAL_W-1] ^ i_den[VAL_W-1];
        end else if (r_run) begin
            r_rem <= w_qbit ? VAL_W'(w_trial - {1'b0, r_den}) : w_trial[VAL_W-1:0];
            r_num <= {r_num[NUM_W-2:0], w_qbit};
        end
    end

    assign w_q32  = r_num[VAL_W-1:0];
    assign o_done = r_done;
    assign o_sat  = r_neg ? (r_num > LIM_N) : (r_num > LIM_P);

    always_comb begin
        if (o_sat) begin
            o_quot = r_neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            o_quot = r_neg ? $signed(VAL_W'(0) - w_q32) : $signed(w_q32);
        end
    end

endmodule

// ===== rtl/ges_cell.sv =====
// One column cell of the solver chain: stored and working column, pivot and
// solution registers, and a three-stage multiply-subtract on passing tokens.
// Uses ges_pkg.
module ges_cell import ges_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int COL       = 0,
    parameter int IS_RHS    = 0,
    localparam int AW = $clog2(MAX_DIM),
    localparam int NW = $clog2(MAX_DIM + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [AW-1:0]           i_ld_row,
    input  logic [AW-1:0]           i_ld_col,
    input  logic [AW-1:0]           i_copy_row,
    input  logic [AW-1:0]           i_probe_row,
    input  logic [AW-1:0]           i_step,
    input  logic [NW-1:0]           i_n,
    input  logic signed [VAL_W-1:0] i_wdata,
    input  t_tok                    i_tok,
    input  logic [AW-1:0]           i_tok_row,
    output t_tok                    o_tok,
    output logic [AW-1:0]           o_tok_row,
    output logic signed [VAL_W-1:0] o_rd,
    output logic signed [VAL_W-1:0] o_x,
    output logic                    o_sat
);
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] QMAX = 65'sd2147483647;
    localparam logic signed [64:0] QMIN = -65'sd2147483648;

    logic signed [VAL_W-1:0] r_stor [MAX_DIM];
    logic signed [VAL_W-1:0] r_work [MAX_DIM];
    logic signed [VAL_W-1:0] r_rd;
    logic signed [VAL_W-1:0] r_cp_data;
    logic [AW-1:0]           r_cp_row;
    logic                    r_cp_v;
    logic signed [VAL_W-1:0] r_piv;
    logic signed [VAL_W-1:0] r_x;

    t_tok                    r_t1, r_t2, r_t3;
    logic [AW-1:0]           r_row1, r_row2, r_row3;
    logic signed [63:0]      r_prod;
    logic signed [VAL_W-1:0] r_c;
    logic                    r_act2;

    logic                    w_ld;
    logic                    w_xwe;
    logic [AW-1:0]           w_raddr;
    logic                    w_act;
    logic signed [VAL_W-1:0] w_a, w_b;
    logic signed [63:0]      w_prod;
    logic signed [63:0]      w_rnd;
    logic signed [64:0]      w_diff;
    logic                    w_hi, w_lo;
    logic signed [VAL_W-1:0] w_clip;
    logic                    w_wb;

    assign w_ld  = (IS_RHS != 0) ? i_ctl.ld_rhs
                                 : (i_ctl.ld_mat && (32'(i_ld_col) == COL));
    assign w_xwe = (IS_RHS == 0) && i_ctl.x_we && (32'(i_step) == COL);
    assign w_raddr = i_tok.valid ? i_tok_row : i_probe_row;

    always_comb begin
        if (r_t1.bs) begin
            w_act = (IS_RHS == 0) && (COL > 32'(i_step)) && (COL < 32'(i_n));
        end else begin
            w_act = (IS_RHS != 0) || ((COL >= 32'(i_step)) && (COL < 32'(i_n)));
        end
    end

    assign w_a    = r_t1.bs ? r_rd : r_t1.val;
    assign w_b    = r_t1.bs ? r_x  : r_piv;
    assign w_prod = w_a * w_b;
    assign w_rnd  = (r_prod + RND_HALF) >>> FRAC_BITS;
    assign w_diff = 65'(r_c) - 65'(w_rnd);
    assign w_hi   = w_diff > QMAX;
    assign w_lo   = w_diff < QMIN;
    assign w_clip = w_hi ? 32'sh7FFF_FFFF : (w_lo ? 32'sh8000_0000 : $signed(w_diff[31:0]));
    assign w_wb   = r_t2.valid && !r_t2.bs && r_act2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_v   <= 1'b0;
            r_t1.valid <= 1'b0;
            r_t2.valid <= 1'b0;
            r_t3.valid <= 1'b0;
        end else begin
            r_cp_v     <= i_ctl.copy;
            r_t1.valid <= i_tok.valid;
            r_t2.valid <= r_t1.valid;
            r_t3.valid <= r_t2.valid;
        end
        // token pipeline payload
        r_t1.bs  <= i_tok.bs;
        r_t1.val <= i_tok.val;
        r_t2.bs  <= r_t1.bs;
        r_t2.val <= r_t1.val;
        r_t3.bs  <= r_t2.bs;
        r_t3.val <= (r_t2.bs && r_act2) ? w_clip : r_t2.val;
    end

    always_ff @(posedge i_clk) begin
        if (w_ld) begin
            r_stor[i_ld_row] <= i_wdata;
        end
        r_cp_data <= r_stor[i_copy_row];
        r_cp_row  <= i_copy_row;
        if (r_cp_v) begin
            r_work[r_cp_row] <= r_cp_data;
        end else if (w_wb) begin
            r_work[r_row2] <= w_clip;
        end
        r_rd <= r_work[w_raddr];
        if (i_ctl.piv_ld) begin
            r_piv <= r_rd;
        end
        if (w_xwe) begin
            r_x <= i_wdata;
        end
        r_row1   <= i_tok_row;
        r_prod   <= w_prod;
        r_c      <= r_t1.bs ? r_t1.val : r_rd;
        r_act2   <= w_act;
        r_row2   <= r_row1;
        r_row3   <= r_row2;
    end

    assign o_tok     = r_t3;
    assign o_tok_row = r_row3;
    assign o_rd      = r_rd;
    assign o_x       = r_x;
    assign o_sat     = r_t2.valid && r_act2 && (w_hi || w_lo);

endmodule

// ===== rtl/gaussian_elimination_solver_top.sv =====
// Usage: solves A x = b in signed fixed point by elimination without pivoting.
// Channels (valid/ready, transfer when both high):
//   i_cfg: writes the dimension register (reset 16; 0 acts as 1, above
//          MAX_DIM acts as MAX_DIM). Always ready; write only when idle.
//   i_in:  opcode 0 loads A[row][column], 1 loads b[row], 2 solves, 3 ignored.
//          Each load is written on its transfer. A and b are kept across solves.
//   o_out: per solve, n results x[0]..x[n-1], last on x[n-1]; on a zero pivot
//          a single result with singular set, value 0, index 0.
// Sequence: a solve copies the stored column arrays, then each eliminated row
//   takes a probe read and check (S_LEAD_RD, S_LEAD_CHK), one divide and one
//   pass down the chain of MAX_DIM+1 column cells; each pivot is read and
//   checked (S_PIV_RD, S_PIV_CHK); back substitution takes the same steps as
//   a row per unknown. Results then follow at one a cycle while o_out is ready.
//   i_in is not ready from a solve until its last result is transferred.
// Reset (synchronous, active low) clears control state only; stores hold
//   whatever was written. A stalled o_out holds its result.
// Depends on ges_pkg, ges_if, ges_cell, ges_div.
module gaussian_elimination_solver_top import ges_pkg::*; #(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ges_cfg_if.sink   i_cfg,
    ges_in_if.sink    i_in,
    ges_out_if.source o_out
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int NW = $clog2(MAX_DIM + 1);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_COPY     = 13'b0000000000010,
        S_PIV_RD   = 13'b0000000000100,
        S_PIV_CHK  = 13'b0000000001000,
        S_LEAD_RD  = 13'b0000000010000,
        S_LEAD_CHK = 13'b0000000100000,
        S_DIV_E    = 13'b0000001000000,
        S_ELIM     = 13'b0000010000000,
        S_BS_RD    = 13'b0000100000000,
        S_BS_CHK   = 13'b0001000000000,
        S_BS_RUN   = 13'b0010000000000,
        S_BS_DIV   = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } t_state;

    t_state                  r_state;
    logic [DIM_W-1:0]        r_dim;
    logic [NW-1:0]           r_n;
    logic [AW-1:0]           r_i, r_k, r_cnt;
    logic signed [VAL_W-1:0] r_p;
    logic                    r_sat, r_sing;
    t_tok                    r_inj;
    logic [AW-1:0]           r_inj_row;

    t_ctl                    w_ctl;
    logic                    w_in_xfer;
    logic                    w_out_xfer;
    logic [NW-1:0]           w_n_new;
    logic [AW-1:0]           w_probe;
    logic signed [VAL_W-1:0] w_wdata;
    logic                    w_more_k, w_more_i;
    logic                    w_last;

    t_tok                    w_tok     [MAX_DIM+1];
    logic [AW-1:0]           w_tok_row [MAX_DIM+1];
    logic signed [VAL_W-1:0] w_rd      [MAX_DIM];
    logic signed [VAL_W-1:0] w_x       [MAX_DIM];
    logic [MAX_DIM-1:0]      w_sat;
    t_tok                    w_tok_end;
    logic signed [VAL_W-1:0] w_rhs_rd;
    logic                    w_rhs_sat;

    logic                    w_div_start;
    logic signed [VAL_W-1:0] w_div_num;
    logic                    w_div_done;
    logic signed [VAL_W-1:0] w_div_quot;
    logic                    w_div_sat;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_out_xfer  = o_out.valid && o_out.ready;

    always_comb begin
        if (r_dim == '0) begin
            w_n_new = NW'(1);
        end else if (32'(r_dim) > MAX_DIM) begin
            w_n_new = NW'(MAX_DIM);
        end else begin
            w_n_new = NW'(r_dim);
        end
    end

    assign w_more_k = (NW'(r_k) + NW'(1)) < r_n;
    assign w_more_i = (NW'(r_i) + NW'(1)) < r_n;
    assign w_probe  = (r_state == S_LEAD_RD) ? r_k : r_i;
    assign w_wdata  = (r_state == S_IDLE) ? i_in.value : w_div_quot;

    always_comb begin
        w_ctl        = '0;
        w_ctl.ld_mat = w_in_xfer && (t_op'(i_in.opcode) == OP_LOAD_MAT)
                       && (32'(i_in.row) < MAX_DIM) && (32'(i_in.column) < MAX_DIM);
        w_ctl.ld_rhs = w_in_xfer && (t_op'(i_in.opcode) == OP_LOAD_RHS)
                       && (32'(i_in.row) < MAX_DIM);
        w_ctl.copy   = (r_state == S_COPY);
        w_ctl.piv_ld = (r_state == S_PIV_CHK);
        w_ctl.x_we   = (r_state == S_BS_DIV) && w_div_done;
    end

    assign w_div_start = ((r_state == S_LEAD_CHK) && (w_rd[r_i] != '0))
                         || ((r_state == S_BS_RUN) && w_tok_end.valid);
    assign w_div_num   = (r_state == S_LEAD_CHK) ? w_rd[r_i] : w_tok_end.val;

    assign w_tok[0]     = r_inj;
    assign w_tok_row[0] = r_inj_row;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        ges_cell #(
            .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .COL(g), .IS_RHS(0)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
            .i_ld_row(AW'(i_in.row)), .i_ld_col(AW'(i_in.column)),
            .i_copy_row(r_cnt), .i_probe_row(w_probe), .i_step(r_i), .i_n(r_n),
            .i_wdata(w_wdata), .i_tok(w_tok[g]), .i_tok_row(w_tok_row[g]),
            .o_tok(w_tok[g+1]), .o_tok_row(w_tok_row[g+1]),
            .o_rd(w_rd[g]), .o_x(w_x[g]), .o_sat(w_sat[g])
        );
    end

    ges_cell #(
        .MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS), .COL(MAX_DIM), .IS_RHS(1)
    ) u_rhs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_ld_row(AW'(i_in.row)), .i_ld_col(AW'(i_in.column)),
        .i_copy_row(r_cnt), .i_probe_row(w_probe), .i_step(r_i), .i_n(r_n),
        .i_wdata(w_wdata), .i_tok(w_tok[MAX_DIM]), .i_tok_row(w_tok_row[MAX_DIM]),
        .o_tok(w_tok_end), .o_tok_row(),
        .o_rd(w_rhs_rd), .o_x(), .o_sat(w_rhs_sat)
    );

    ges_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_div_num), .i_den(r_p),
        .o_done(w_div_done), .o_quot(w_div_quot), .o_sat(w_div_sat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dim     <= DIM_RESET;
            r_inj.valid <= 1'b0;
            r_sat     <= 1'b0;
            r_sing    <= 1'b0;
            r_n       <= NW'(1);
            r_i       <= '0;
            r_k       <= '0;
            r_cnt     <= '0;
        end else begin
            r_inj.valid <= ((r_state == S_DIV_E) && w_div_done) || (r_state == S_BS_CHK);
            if (i_cfg.valid && i_cfg.ready) begin
                r_dim <= i_cfg.data;
            end
            if ((r_state == S_IDLE) && w_in_xfer && (t_op'(i_in.opcode) == OP_SOLVE)) begin
                r_sat <= 1'b0;
            end else if ((|w_sat) || w_rhs_sat || (w_div_done && w_div_sat)) begin
                r_sat <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && (t_op'(i_in.opcode) == OP_SOLVE)) begin
                        r_n     <= w_n_new;
                        r_sing  <= 1'b0;
                        r_cnt   <= '0;
                        r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    r_cnt <= r_cnt + AW'(1);
                    if (32'(r_cnt) == MAX_DIM - 1) begin
                        r_i     <= '0;
                        r_state <= S_PIV_RD;
                    end
                end
                S_PIV_RD: r_state <= S_PIV_CHK;
                S_PIV_CHK: begin
                    if (w_rd[r_i] == '0) begin
                        r_sing  <= 1'b1;
                        r_cnt   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_p <= w_rd[r_i];
                        if (w_more_i) begin
                            r_k     <= r_i + AW'(1);
                            r_state <= S_LEAD_RD;
                        end else begin
                            r_state <= S_BS_RD;
                        end
                    end
                end
                S_LEAD_RD: r_state <= S_LEAD_CHK;
                S_LEAD_CHK, S_ELIM: begin
                    if (((r_state == S_LEAD_CHK) && (w_rd[r_i] != '0))) begin
                        r_state <= S_DIV_E;
                    end else if ((r_state == S_LEAD_CHK) || w_tok_end.valid) begin
                        if (w_more_k) begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_LEAD_RD;
                        end else if (w_more_i) begin
                            r_i     <= r_i + AW'(1);
                            r_state <= S_PIV_RD;
                        end else begin
                            r_i     <= AW'(r_n - NW'(1));
                            r_state <= S_BS_RD;
                        end
                    end
                end
                S_DIV_E: begin
                    if (w_div_done) begin
                        r_inj.bs    <= 1'b0;
                        r_inj.val   <= w_div_quot;
                        r_inj_row   <= r_k;
                        r_state     <= S_ELIM;
                    end
                end
                S_BS_RD: r_state <= S_BS_CHK;
                S_BS_CHK: begin
                    r_p         <= w_rd[r_i];
                    r_inj.bs    <= 1'b1;
                    r_inj.val   <= w_rhs_rd;
                    r_inj_row   <= r_i;
                    r_state     <= S_BS_RUN;
                end
                S_BS_RUN: begin
                    if (w_tok_end.valid) begin
                        r_state <= S_BS_DIV;
                    end
                end
                S_BS_DIV: begin
                    if (w_div_done) begin
                        if (r_i == '0) begin
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i - AW'(1);
                            r_state <= S_BS_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_xfer) begin
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= r_cnt + AW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_last               = r_sing || ((NW'(r_cnt) + NW'(1)) == r_n);
    assign o_out.valid          = (r_state == S_OUT);
    assign o_out.solution_index = r_sing ? 4'd0 : 4'(r_cnt);
    assign o_out.solution_value = r_sing ? 32'sd0 : w_x[r_cnt];
    assign o_out.singular       = r_sing;
    assign o_out.overflowed     = r_sat;
    assign o_out.last           = w_last;

`ifndef ASSERT_OFF
    a_sing_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.singular) |-> (o_out.solution_value == 0 && o_out.last))
        else $error("singular result not zero or not last");

    a_chain_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok_end.valid |-> (r_state == S_ELIM || r_state == S_BS_RUN))
        else $error("token left the chain outside a wait state");

    a_busy_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !i_in.ready)
        else $error("divider started while input is ready");
`endif

endmodule
